// ===== hw/rtl/i2c_master_byte_engine_top_macros.svh =====
// Assertion macros used by the I2C master byte engine checker.
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define I2CM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cm assertion failed");

// next-cycle implication, held off during reset
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cm assertion failed");

`endif

// ===== hw/rtl/i2cm_pkg.sv =====
// Package: types and constants of the I2C master byte engine.
`timescale 1ns / 1ps
package i2cm_pkg;

    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] UNIT_TICKS_RST = 16'd36;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_READ  = 3'd4
    } t_action;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_ST1   = 5'd1,
        PH_ST2   = 5'd2,
        PH_ST3   = 5'd3,
        PH_SP1   = 5'd4,
        PH_SP2   = 5'd5,
        PH_SP3   = 5'd6,
        PH_WSET  = 5'd7,
        PH_WHI   = 5'd8,
        PH_WLO   = 5'd9,
        PH_WAHI  = 5'd10,
        PH_WALO  = 5'd11,
        PH_RREL  = 5'd12,
        PH_RHI   = 5'd13,
        PH_RLO   = 5'd14,
        PH_RASET = 5'd15,
        PH_RAHI  = 5'd16,
        PH_RALO  = 5'd17
    } t_phase;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_cmd;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack_seen;
    } t_res;

endpackage

// ===== hw/rtl/i2cm_in_if.sv =====
// Command channel: one tick beat with an optional command.
`timescale 1ns / 1ps
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, output action, output tx_byte, output send_ack,
                    output sda_in, input ready);
    modport sink (input valid, input action, input tx_byte, input send_ack,
                  input sda_in, output ready);
endinterface

// ===== hw/rtl/i2cm_out_if.sv =====
// Result channel: line levels and status for one tick beat.
`timescale 1ns / 1ps
interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_seen;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output rx_byte, output nack_seen, input ready);
    modport sink (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input rx_byte, input nack_seen, output ready);
endinterface

// ===== hw/rtl/i2cm_core.sv =====
// Line sequencer: phase, unit timing, bit shifting and status registers.
`timescale 1ns / 1ps
module i2cm_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  i2cm_pkg::t_cmd           i_cmd,
    input  logic [i2cm_pkg::CFG_W-1:0] i_unit_last,
    output i2cm_pkg::t_res           o_res
);
    import i2cm_pkg::*;

    t_phase            r_phase, n_phase;
    logic [CFG_W-1:0]  r_unit_count, n_unit_count;
    logic [2:0]        r_units_left, n_units_left;
    logic [2:0]        r_bit_index, n_bit_index;
    logic [7:0]        r_shift, n_shift;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic              r_ack_flag, n_ack_flag;
    logic              r_ack_bit, n_ack_bit;
    logic [7:0]        r_rx, n_rx;
    logic              w_done;
    logic              w_scl_now;
    logic              w_sda_now;

    always_comb begin
        n_phase      = r_phase;
        n_unit_count = r_unit_count;
        n_units_left = r_units_left;
        n_bit_index  = r_bit_index;
        n_shift      = r_shift;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_ack_flag   = r_ack_flag;
        n_ack_bit    = r_ack_bit;
        n_rx         = r_rx;
        w_done       = 1'b0;

        // command decode, idle only
        if (r_phase == PH_IDLE) begin
            n_bit_index = '0;
            case (t_action'(i_cmd.action))
                ACT_START: begin
                    n_phase = PH_ST1; n_units_left = 3'd2; n_unit_count = '0;
                    n_scl = 1'b1; n_sda = 1'b1;
                end
                ACT_STOP: begin
                    n_phase = PH_SP1; n_units_left = 3'd2; n_unit_count = '0;
                    n_scl = 1'b0; n_sda = 1'b0;
                end
                ACT_WRITE: begin
                    n_shift = i_cmd.tx_byte;
                    n_phase = PH_WSET; n_units_left = 3'd1; n_unit_count = '0;
                    n_sda = i_cmd.tx_byte[7];
                end
                ACT_READ: begin
                    n_shift = '0;
                    n_ack_bit = i_cmd.send_ack;
                    n_phase = PH_RREL; n_units_left = 3'd1; n_unit_count = '0;
                    n_sda = 1'b1;
                end
                default: begin
                end
            endcase
        end

        w_scl_now = n_scl;
        w_sda_now = n_sda;

        if (n_phase != PH_IDLE) begin
            if (n_unit_count >= i_unit_last) begin
                n_unit_count = '0;
                if (n_units_left != 3'd0) begin
                    n_units_left = n_units_left - 3'd1;
                end
                if (n_units_left == 3'd0) begin
                    // segment end: move to the next segment
                    case (n_phase)
                        PH_ST1: begin
                            n_phase = PH_ST2; n_units_left = 3'd2; n_sda = 1'b0;
                        end
                        PH_ST2: begin
                            n_phase = PH_ST3; n_units_left = 3'd1; n_scl = 1'b0;
                        end
                        PH_SP1: begin
                            n_phase = PH_SP2; n_units_left = 3'd2; n_scl = 1'b1;
                        end
                        PH_SP2: begin
                            n_phase = PH_SP3; n_units_left = 3'd4; n_sda = 1'b1;
                        end
                        PH_WSET: begin
                            n_phase = PH_WHI; n_units_left = 3'd3; n_scl = 1'b1;
                        end
                        PH_WHI: begin
                            n_phase = PH_WLO; n_units_left = 3'd3; n_scl = 1'b0;
                        end
                        PH_WLO: begin
                            if (n_bit_index == 3'd7) begin
                                n_phase = PH_WAHI; n_units_left = 3'd3;
                                n_scl = 1'b1; n_sda = 1'b1;
                            end else begin
                                n_bit_index = n_bit_index + 3'd1;
                                n_sda = n_shift[6];
                                n_shift = {n_shift[6:0], 1'b0};
                                n_phase = PH_WSET; n_units_left = 3'd1;
                            end
                        end
                        PH_WAHI: begin
                            n_ack_flag = i_cmd.sda_in;
                            n_phase = PH_WALO; n_units_left = 3'd3; n_scl = 1'b0;
                        end
                        PH_RREL: begin
                            n_phase = PH_RHI; n_units_left = 3'd3; n_scl = 1'b1;
                        end
                        PH_RHI: begin
                            n_shift = {n_shift[6:0], i_cmd.sda_in};
                            n_phase = PH_RLO; n_units_left = 3'd3; n_scl = 1'b0;
                        end
                        PH_RLO: begin
                            if (n_bit_index == 3'd7) begin
                                n_phase = PH_RASET; n_units_left = 3'd1;
                                n_sda = !n_ack_bit;
                            end else begin
                                n_bit_index = n_bit_index + 3'd1;
                                n_phase = PH_RHI; n_units_left = 3'd3; n_scl = 1'b1;
                            end
                        end
                        PH_RASET: begin
                            n_phase = PH_RAHI; n_units_left = 3'd3; n_scl = 1'b1;
                        end
                        PH_RAHI: begin
                            n_phase = PH_RALO; n_units_left = 3'd3;
                            n_scl = 1'b0; n_sda = 1'b1;
                        end
                        PH_RALO: begin
                            n_rx = n_shift;
                            n_phase = PH_IDLE;
                            w_done = 1'b1;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            w_done = 1'b1;
                        end
                    endcase
                end
            end else begin
                n_unit_count = n_unit_count + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_unit_count <= '0;
            r_units_left <= '0;
            r_bit_index  <= '0;
            r_shift      <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_ack_flag   <= 1'b0;
            r_ack_bit    <= 1'b0;
            r_rx         <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_unit_count <= n_unit_count;
            r_units_left <= n_units_left;
            r_bit_index  <= n_bit_index;
            r_shift      <= n_shift;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_ack_flag   <= n_ack_flag;
            r_ack_bit    <= n_ack_bit;
            r_rx         <= n_rx;
        end
    end

    assign o_res.scl_out   = w_scl_now;
    assign o_res.sda_out   = w_sda_now;
    assign o_res.busy_res  = (n_phase != PH_IDLE);
    assign o_res.done_res  = w_done;
    assign o_res.rx_byte   = n_rx;
    assign o_res.nack_seen = n_ack_flag;

endmodule

// ===== hw/rtl/i2c_master_byte_engine_top.sv =====
// A taken tick beat's result beat is registered in the output stage before it is offered.
// Throughput: one tick beat per cycle while the skid entry is empty; a two-entry
// output stage keeps ready high while one result waits. Line timing is units of
// unit_ticks beats each. Reset (synchronous, active low) idles the sequencer,
// releases SCL and SDA, empties the output stage and sets unit_ticks to 36.
`timescale 1ns / 1ps
module i2c_master_byte_engine_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [i2cm_pkg::CFG_W-1:0]   i_cfg_wr_data,
    i2cm_in_if.sink                      i_cmd,
    i2cm_out_if.source                   o_res
);
    import i2cm_pkg::*;

    logic [CFG_W-1:0] r_unit_last;
    t_cmd             w_cmd;
    t_res             w_res;
    logic             w_fire;
    logic             w_out_ready;
    t_res             r_out;
    logic             r_out_valid;
    t_res             r_skid;
    logic             r_skid_valid;

    // zero unit_ticks behaves as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_last <= UNIT_TICKS_RST - 16'd1;
        end else if (i_cfg_wr_en) begin
            r_unit_last <= (i_cfg_wr_data == '0) ? '0 : i_cfg_wr_data - 16'd1;
        end
    end

    assign w_cmd.action   = i_cmd.action;
    assign w_cmd.tx_byte  = i_cmd.tx_byte;
    assign w_cmd.send_ack = i_cmd.send_ack;
    assign w_cmd.sda_in   = i_cmd.sda_in;

    assign i_cmd.ready = !r_skid_valid;
    assign w_fire      = i_cmd.valid && !r_skid_valid;
    assign w_out_ready = o_res.ready;

    i2cm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_cmd       (w_cmd),
        .i_unit_last (r_unit_last),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_fire) begin
            if (r_out_valid && !w_out_ready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_ready) begin
                r_out <= r_skid;
            end
        end else if (w_fire) begin
            if (r_out_valid && !w_out_ready) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_out   = r_out.scl_out;
    assign o_res.sda_out   = r_out.sda_out;
    assign o_res.busy_res  = r_out.busy_res;
    assign o_res.done_res  = r_out.done_res;
    assign o_res.rx_byte   = r_out.rx_byte;
    assign o_res.nack_seen = r_out.nack_seen;

endmodule

// ===== hw/rtl/i2cm_checker.sv =====
// Port checker for the I2C master byte engine, bound to the top level.
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_top_macros.svh"
module i2cm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_busy_res,
    input logic i_done_res
);
    // a finished command is never reported busy in the same beat
    `I2CM_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, i_out_valid && i_done_res, !i_busy_res)
    // every taken tick beat yields a pending result beat
    `I2CM_ASSERT_NEXT(a_in_gives_out, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid)
    // output stage empty right after reset
    `I2CM_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid)
    // a stalled result beat stays offered
    `I2CM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_busy_res  (o_res.busy_res),
    .i_done_res  (o_res.done_res)
);

// ===== verif/i2c_master_byte_engine_top_test.sv =====
// Testbench: I2C master byte engine, directed table plus random command traffic vs a line model.
`timescale 1ns / 1ps
module i2c_master_byte_engine_top_test;
    import i2cm_pkg::*;

    localparam int KEEP = -1;
    localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI  = 3'd7;
    localparam int MAX_GAP = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_PRINTS = 60;

    localparam t_res IDLE_AFTER_RST = '{scl_out: 1'b1, sda_out: 1'b1, default: '0};

    typedef struct packed {
        logic        set_cfg;
        logic [15:0] cfg;
        t_cmd        cmd;
        logic        typed;
        t_res        want;
    } t_dir_row;

    localparam int DIR_N = 23;
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{1'b0, 16'd0, '{ACT_TICK,      8'h00, 1'b0, 1'b0}, 1'b1, IDLE_AFTER_RST},
        '{1'b0, 16'd0, '{ACT_SPARE_LO,  8'hFF, 1'b1, 1'b1}, 1'b1, IDLE_AFTER_RST},
        '{1'b0, 16'd0, '{ACT_SPARE_MID, 8'h00, 1'b0, 1'b1}, 1'b1, IDLE_AFTER_RST},
        '{1'b0, 16'd0, '{ACT_SPARE_HI,  8'h5A, 1'b1, 1'b0}, 1'b1, IDLE_AFTER_RST},
        // start at one tick per unit; commands while busy are dropped
        '{1'b1, 16'd1, '{ACT_START,     8'h00, 1'b0, 1'b1}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_WRITE,     8'hA5, 1'b0, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_READ,      8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_STOP,      8'hFF, 1'b0, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_TICK,      8'h00, 1'b0, 1'b1}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_STOP,      8'hFF, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_TICK,      8'h00, 1'b0, 1'b1}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_TICK,      8'hFF, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_START,     8'h00, 1'b0, 1'b1}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_TICK,      8'h80, 1'b0, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_TICK,      8'h01, 1'b1, 1'b1}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_TICK,      8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_TICK,      8'h00, 1'b0, 1'b1}, 1'b0, '0},
        // zero unit_ticks runs as one
        '{1'b1, 16'd0, '{ACT_START,     8'hFF, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_TICK,      8'h00, 1'b0, 1'b1}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_WRITE,     8'h3C, 1'b0, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_TICK,      8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{1'b0, 16'd0, '{ACT_TICK,      8'h00, 1'b0, 1'b0}, 1'b0, '0},
        // idle after start: lines stay low
        '{1'b0, 16'd0, '{ACT_TICK,      8'hFF, 1'b1, 1'b1}, 1'b0, '0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    i2cm_in_if  cmd_ch ();
    i2cm_out_if res_ch ();

    i2c_master_byte_engine_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd_ch),
        .o_res         (res_ch)
    );

    // line model state
    t_phase      ln_phase;
    logic [15:0] ln_unit_ticks;
    logic [15:0] ln_unit_count;
    logic [2:0]  ln_units_left;
    logic [3:0]  ln_bit_index;
    logic [7:0]  ln_shift;
    logic [7:0]  ln_rx_hold;
    logic        ln_scl;
    logic        ln_sda;
    logic        ln_ack_flag;
    logic        ln_ack_bit;

    t_res line_exp_q [$];
    int unsigned err_count = 0;
    int unsigned res_beats = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit press_go = 1'b0;
    logic res_hold = 1'b0;

    function automatic void seg_enter(t_phase ph, logic [2:0] units, int scl, int sda);
        ln_phase = ph;
        ln_units_left = units;
        ln_unit_count = '0;
        if (scl >= 0) ln_scl = scl[0];
        if (sda >= 0) ln_sda = sda[0];
    endfunction

    function automatic logic seg_close(logic sda);
        logic fin;
        fin = 1'b0;
        case (ln_phase)
            PH_ST1:   seg_enter(PH_ST2, 3'd2, KEEP, 0);
            PH_ST2:   seg_enter(PH_ST3, 3'd1, 0, KEEP);
            PH_SP1:   seg_enter(PH_SP2, 3'd2, 1, KEEP);
            PH_SP2:   seg_enter(PH_SP3, 3'd4, KEEP, 1);
            PH_WSET:  seg_enter(PH_WHI, 3'd3, 1, KEEP);
            PH_WHI:   seg_enter(PH_WLO, 3'd3, 0, KEEP);
            PH_WLO: begin
                if (ln_bit_index >= 4'd7) begin
                    seg_enter(PH_WAHI, 3'd3, 1, 1);
                end else begin
                    ln_bit_index++;
                    ln_shift = ln_shift << 1;
                    seg_enter(PH_WSET, 3'd1, KEEP, int'(ln_shift[7]));
                end
            end
            PH_WAHI: begin
                ln_ack_flag = sda;
                seg_enter(PH_WALO, 3'd3, 0, KEEP);
            end
            PH_RREL:  seg_enter(PH_RHI, 3'd3, 1, KEEP);
            PH_RHI: begin
                ln_shift = {ln_shift[6:0], sda};
                seg_enter(PH_RLO, 3'd3, 0, KEEP);
            end
            PH_RLO: begin
                if (ln_bit_index >= 4'd7) begin
                    seg_enter(PH_RASET, 3'd1, KEEP, int'(!ln_ack_bit));
                end else begin
                    ln_bit_index++;
                    seg_enter(PH_RHI, 3'd3, 1, KEEP);
                end
            end
            PH_RASET: seg_enter(PH_RAHI, 3'd3, 1, KEEP);
            PH_RAHI:  seg_enter(PH_RALO, 3'd3, 0, 1);
            PH_RALO: begin
                ln_rx_hold = ln_shift;
                ln_phase = PH_IDLE;
                fin = 1'b1;
            end
            default: begin
                ln_phase = PH_IDLE;
                fin = 1'b1;
            end
        endcase
        return fin;
    endfunction

    // one tick of the line engine for an accepted beat
    function automatic t_res line_tick(t_cmd c);
        t_res        r;
        logic [16:0] ut;
        logic        fin;
        ut = (ln_unit_ticks == '0) ? 17'd1 : {1'b0, ln_unit_ticks};
        fin = 1'b0;
        if (ln_phase == PH_IDLE) begin
            ln_bit_index = '0;
            case (c.action)
                ACT_START: seg_enter(PH_ST1, 3'd2, 1, 1);
                ACT_STOP:  seg_enter(PH_SP1, 3'd2, 0, 0);
                ACT_WRITE: begin
                    ln_shift = c.tx_byte;
                    seg_enter(PH_WSET, 3'd1, KEEP, int'(c.tx_byte[7]));
                end
                ACT_READ: begin
                    ln_shift = '0;
                    ln_ack_bit = c.send_ack;
                    seg_enter(PH_RREL, 3'd1, KEEP, 1);
                end
                default: ;
            endcase
        end
        r.scl_out = ln_scl;
        r.sda_out = ln_sda;
        if (ln_phase != PH_IDLE) begin
            if (ln_unit_count + 17'd1 >= ut) begin
                ln_unit_count = '0;
                if (ln_units_left > 3'd0) ln_units_left--;
                if (ln_units_left == 3'd0) fin = seg_close(c.sda_in);
            end else begin
                ln_unit_count++;
            end
        end
        r.busy_res  = (ln_phase != PH_IDLE);
        r.done_res  = fin;
        r.rx_byte   = ln_rx_hold;
        r.nack_seen = ln_ack_flag;
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        if (err_count < MAX_PRINTS) $display("MISMATCH beat %0d: %s", res_beats, msg);
        err_count++;
    endtask

    task automatic cmp_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) note_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic send_beat(t_cmd c, logic typed, t_res want);
        int   gap;
        t_res pred;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.action   <= c.action;
        cmd_ch.tx_byte  <= c.tx_byte;
        cmd_ch.send_ack <= c.send_ack;
        cmd_ch.sda_in   <= c.sda_in;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        pred = line_tick(c);
        line_exp_q.push_back(typed ? want : pred);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (line_exp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_unit_ticks(logic [15:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        ln_unit_ticks = v;
    endtask

    // command traffic at one unit_ticks setting; ends with the engine idle
    task automatic run_phase(logic [15:0] ut, int budget, bit start_only, bit idle_on);
        int   n;
        int   pick;
        t_cmd c;
        drain_results();
        write_unit_ticks(ut);
        tx_idle_on = idle_on;
        rx_idle_on = idle_on;
        n = 0;
        while (n < budget || ln_phase != PH_IDLE) begin
            c.action   = ACT_TICK;
            c.tx_byte  = 8'($urandom);
            c.send_ack = 1'($urandom);
            c.sda_in   = 1'($urandom);
            pick = $urandom_range(0, 99);
            if (ln_phase == PH_IDLE) begin
                if (start_only) begin
                    if (n == 0) c.action = ACT_START;
                end else if (n == 0 || pick < 75) begin
                    c.action = 3'($urandom_range(ACT_START, ACT_READ));
                end else if (pick < 88) begin
                    c.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
                end
                if (pick % 8 == 0) c.tx_byte = 8'h00;
                else if (pick % 8 == 1) c.tx_byte = 8'hFF;
            end else if (pick < 6) begin
                c.action = 3'($urandom_range(ACT_TICK, ACT_SPARE_HI));
            end
            send_beat(c, 1'b0, '0);
            n++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // long receiver hold-off so the output stage fills and input stalls
    initial begin
        @(posedge i_clk iff press_go);
        repeat (40) @(posedge i_clk);
        res_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        res_hold <= 1'b0;
    end

    initial begin
        int   gap;
        t_res want;
        res_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            while (res_hold) begin
                res_ch.ready <= 1'b0;
                @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            res_beats++;
            if (line_exp_q.size() == 0) begin
                note_mismatch("result beat with nothing expected");
            end else begin
                want = line_exp_q.pop_front();
                cmp_field("scl_out", res_ch.scl_out, want.scl_out);
                cmp_field("sda_out", res_ch.sda_out, want.sda_out);
                cmp_field("busy_res", res_ch.busy_res, want.busy_res);
                cmp_field("done_res", res_ch.done_res, want.done_res);
                cmp_field("rx_byte", res_ch.rx_byte, want.rx_byte);
                cmp_field("nack_seen", res_ch.nack_seen, want.nack_seen);
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.action   = ACT_TICK;
        cmd_ch.tx_byte  = '0;
        cmd_ch.send_ack = 1'b0;
        cmd_ch.sda_in   = 1'b0;

        ln_phase      = PH_IDLE;
        ln_unit_ticks = UNIT_TICKS_RST;
        ln_unit_count = '0;
        ln_units_left = '0;
        ln_bit_index  = '0;
        ln_shift      = '0;
        ln_rx_hold    = '0;
        ln_scl        = 1'b1;
        ln_sda        = 1'b1;
        ln_ack_flag   = 1'b0;
        ln_ack_bit    = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            if (DIR_ROWS[i].set_cfg) begin
                drain_results();
                write_unit_ticks(DIR_ROWS[i].cfg);
            end
            send_beat(DIR_ROWS[i].cmd, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        press_go = 1'b1;
        run_phase(16'd2, 120, 1'b0, 1'b1);
        run_phase(16'd1, 120, 1'b0, 1'b0);
        run_phase(16'd3, 100, 1'b0, 1'b1);
        run_phase(16'd0, 80, 1'b0, 1'b1);
        run_phase(16'd7, 50, 1'b0, 1'b1);
        run_phase(16'd1, 100, 1'b0, 1'b1);
        run_phase(UNIT_TICKS_RST, 1, 1'b1, 1'b1);
        run_phase(16'd2, 70, 1'b0, 1'b1);
        drain_results();

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
